// ----- rtl/conv3x3_rgb_valid_top_assert.svh -----
// Assertion macros shared by the filter design.
`ifndef CONV3X3_RGB_VALID_TOP_ASSERT_SVH
`define CONV3X3_RGB_VALID_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CV3_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("conv3x3 assertion failed");

// Next-cycle implication.
`define CV3_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("conv3x3 assertion failed");

`endif

// ----- rtl/cv3_pkg.sv -----
package cv3_pkg;

	localparam int LINE_MAX       = 1024;
	localparam int KERNEL_SIZE    = 3;
	localparam int COEF_FRAC_BITS = 14;

	localparam int NUM_TAPS = KERNEL_SIZE * KERNEL_SIZE;
	localparam int COL_W    = $clog2(LINE_MAX);
	localparam int ROW_W    = 12;
	localparam int LW_W     = 11;
	localparam int GEO_W    = (COL_W + 2 > ROW_W + 1) ? COL_W + 2 : ROW_W + 1;
	localparam int PIX_W    = 24;
	localparam int COEF_W   = 16;
	localparam int CFG_W    = 48;
	localparam int IDX_W    = 3;
	localparam int PROD_W   = COEF_W + 9;
	localparam int SUM_W    = PROD_W + 4;

	localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_COEF_TOP     = 3'd2;
	localparam logic [IDX_W-1:0] REG_COEF_MID     = 3'd3;
	localparam logic [IDX_W-1:0] REG_COEF_BOT     = 3'd4;

	localparam logic [LW_W-1:0]  RST_LINE_WIDTH   = 11'd640;
	localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = 12'd480;
	localparam logic [CFG_W-1:0] RST_COEF_EDGE    = 48'd5476215686395;
	localparam logic [CFG_W-1:0] RST_COEF_MID     = 48'd8676043720676;

	typedef logic [NUM_TAPS-1:0][7:0]        tap_pix_t;
	typedef logic [NUM_TAPS-1:0][COEF_W-1:0] tap_coef_t;

endpackage

// ----- rtl/cv3_ram.sv -----
module cv3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/cv3_lane.sv -----
module cv3_lane import cv3_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  tap_pix_t  taps,
	input  tap_coef_t coefs,
	output logic [7:0] result
);

	logic signed [PROD_W-1:0] prod_s2 [NUM_TAPS];
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [SUM_W-1:0]  sum_c;
	logic [SUM_W-COEF_FRAC_BITS-1:0] quot;

	// Multiply each tap, pixel taken as a positive signed value.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				prod_s2[i] <= PROD_W'($signed(coefs[i]) * $signed({1'b0, taps[i]}));
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NUM_TAPS; i++) begin
			sum_c = sum_c + SUM_W'(prod_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum_c;
		end
	end

	// Drop fraction bits, clamp to 0..255.
	assign quot = sum_s3[SUM_W-1:COEF_FRAC_BITS];

	always_comb begin
		if (sum_s3[SUM_W-1]) begin
			result = 8'd0;
		end else if (quot > (SUM_W-COEF_FRAC_BITS)'(255)) begin
			result = 8'd255;
		end else begin
			result = quot[7:0];
		end
	end

endmodule

// ----- rtl/conv3x3_rgb_valid_top.sv -----
// 3x3 valid convolution of an RGB stream, one lane per color channel.
// Pipeline from accept to out_valid: line-store read at accept, then multiply,
// sum, output register. Throughput: one item per clock while out_ready does not stall
// the output register, set by the single read port per line store and the fully pipelined lanes.
// Reset: asynchronous active-low arst_n clears counters, window, valids and
// restores default geometry and Gaussian coefficients; line stores are not cleared.
module conv3x3_rgb_valid_top import cv3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// input pixel channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_red,
	input  logic [7:0]       in_green,
	input  logic [7:0]       in_blue,
	input  logic             frame_start,
	// result pixel channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic             row_end,
	output logic             frame_end
);

	// Configuration registers
	logic [LW_W-1:0]  line_width_q;
	logic [ROW_W-1:0] frame_height_q;
	logic [CFG_W-1:0] coef_q [KERNEL_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= RST_LINE_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			coef_q[0]      <= RST_COEF_EDGE;
			coef_q[1]      <= RST_COEF_MID;
			coef_q[2]      <= RST_COEF_EDGE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LINE_WIDTH:   line_width_q   <= cfg_data[LW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[ROW_W-1:0];
				REG_COEF_TOP:     coef_q[0]      <= cfg_data;
				REG_COEF_MID:     coef_q[1]      <= cfg_data;
				REG_COEF_BOT:     coef_q[2]      <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Global pipeline advance: the whole pipe moves when the output register
	// is empty or being drained. Bubbles move with it.
	logic adv;
	logic in_fire;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign in_fire  = in_valid && adv;

	// Clamp geometry to the legal range.
	logic [GEO_W-1:0] w_eff, h_eff, lw_ext, fh_ext;
	assign lw_ext = GEO_W'(line_width_q);
	assign fh_ext = GEO_W'(frame_height_q);

	always_comb begin
		if (lw_ext < GEO_W'(3)) begin
			w_eff = GEO_W'(3);
		end else if (lw_ext > GEO_W'(LINE_MAX)) begin
			w_eff = GEO_W'(LINE_MAX);
		end else begin
			w_eff = lw_ext;
		end
		h_eff = (fh_ext < GEO_W'(3)) ? GEO_W'(3) : fh_ext;
	end

	// Raster position counters; frame_start forces row 0, column 0.
	logic [COL_W-1:0] col_q, col_c;
	logic [ROW_W-1:0] row_q, row_c;
	logic             last_col, last_row, emit_c;

	assign col_c    = frame_start ? '0 : col_q;
	assign row_c    = frame_start ? '0 : row_q;
	assign last_col = (GEO_W'(col_c) + GEO_W'(1)) >= w_eff;
	assign last_row = (GEO_W'(row_c) + GEO_W'(1)) >= h_eff;
	assign emit_c   = (row_c >= ROW_W'(2)) && (col_c >= COL_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_c + ROW_W'(1);
			end else begin
				col_q <= col_c + COL_W'(1);
				row_q <= row_c;
			end
		end
	end

	// Stage 1: line-store read data arrives alongside the pixel.
	logic             v_s1, emit_s1, re_s1, fe_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] px_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_up_s1, fwd_lo_s1;
	logic [PIX_W-1:0] up_rd, lo_rd, cur_up, cur_lo;
	logic             st_we;

	// Forward the item ahead when it writes the column being read now.
	assign cur_up = fwd_s1 ? fwd_up_s1 : up_rd;
	assign cur_lo = fwd_s1 ? fwd_lo_s1 : lo_rd;
	assign st_we  = adv && v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1     <= {in_blue, in_green, in_red};
			col_s1    <= col_c;
			emit_s1   <= emit_c;
			re_s1     <= last_col;
			fe_s1     <= last_col && last_row;
			fwd_s1    <= v_s1 && (col_s1 == col_c);
			fwd_up_s1 <= cur_lo;
			fwd_lo_s1 <= px_s1;
		end
	end

	// Upper store holds row-2, lower store holds row-1.
	cv3_ram #(.WIDTH(PIX_W), .DEPTH(LINE_MAX)) u_upper_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (col_s1),
		.wdata (cur_lo),
		.re    (adv),
		.raddr (col_c),
		.rdata (up_rd)
	);

	cv3_ram #(.WIDTH(PIX_W), .DEPTH(LINE_MAX)) u_lower_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (col_s1),
		.wdata (px_s1),
		.re    (adv),
		.raddr (col_c),
		.rdata (lo_rd)
	);

	// Window: two previous columns of each of the three rows.
	logic [PIX_W-1:0] wnd_q [KERNEL_SIZE][KERNEL_SIZE-1];
	logic [PIX_W-1:0] cur   [KERNEL_SIZE];

	assign cur[0] = cur_up;
	assign cur[1] = cur_lo;
	assign cur[2] = px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
					wnd_q[r][c] <= '0;
				end
			end
		end else if (st_we) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE - 2; c++) begin
					wnd_q[r][c] <= wnd_q[r][c+1];
				end
				wnd_q[r][KERNEL_SIZE-2] <= cur[r];
			end
		end
	end

	// Unpack taps per channel and coefficients, row-major, left tap first.
	tap_pix_t  taps [3];
	tap_coef_t coefs;
	logic [7:0] lane_res [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE; c++) begin
					if (c < KERNEL_SIZE - 1) begin
						taps[ch][r*KERNEL_SIZE+c] = wnd_q[r][c][8*ch +: 8];
					end else begin
						taps[ch][r*KERNEL_SIZE+c] = cur[r][8*ch +: 8];
					end
				end
			end
		end
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				coefs[r*KERNEL_SIZE+c] = coef_q[r][COEF_W*c +: COEF_W];
			end
		end
	end

	// One lane per color channel: multiply, sum, saturate.
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		cv3_lane u_lane (
			.clk    (clk),
			.en     (adv),
			.taps   (taps[ch]),
			.coefs  (coefs),
			.result (lane_res[ch])
		);
	end

	// Track valid and row/frame flags alongside the lanes.
	logic v_s2, re_s2, fe_s2;
	logic v_s3, re_s3, fe_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s2      <= v_s1 && emit_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	// Merge stage: gather the three lane results into one output pixel; delay the row/frame flags alongside.
	always_ff @(posedge clk) begin
		if (adv) begin
			re_s2     <= re_s1;
			fe_s2     <= fe_s1;
			re_s3     <= re_s2;
			fe_s3     <= fe_s2;
			out_red   <= lane_res[0];
			out_green <= lane_res[1];
			out_blue  <= lane_res[2];
			row_end   <= re_s3;
			frame_end <= fe_s3;
		end
	end

	`include "conv3x3_rgb_valid_top_assert.svh"

	`CV3_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
	`CV3_ASSERT_NOW(a_frame_end_on_row_end, out_valid && frame_end, row_end)
	`CV3_ASSERT_NEXT(a_no_emit_no_result, adv && v_s1 && !emit_s1, !v_s2)
	`CV3_ASSERT_NEXT(a_stall_holds_result, out_valid && !out_ready, out_valid && $stable(v_s3))

endmodule
